/* sv/cl2_pkg.sv */
package cl2_pkg;

    localparam int FRAC       = 56;
    localparam int LOW_MAX    = 19;
    localparam int HIGH_MAX   = 32;
    localparam int CLEN_ITERS = 32;
    localparam int LOG_TERMS  = 20;
    localparam int LOW_BRANCH_TERMS_DEF  = 19;
    localparam int HIGH_BRANCH_TERMS_DEF = 30;

    // range reduction: quotient bits and working width
    localparam int KQ_W  = 10;
    localparam int RED_W = 54;

    typedef logic signed [63:0] q_t;
    typedef logic [58:0] rem_t;
    typedef logic [57:0] den_t;

    typedef struct packed {
        q_t         w;
        q_t         t2l;
        q_t         t2h;
        q_t         bl0;
        q_t         bl1;
        q_t         bl2;
        q_t         bh0;
        q_t         bh1;
        q_t         bh2;
        q_t         ww;
        q_t         cube;
        q_t         dl;
        q_t         s;
        q_t         s2;
        q_t         sum;
        q_t         lg;
        logic [5:0] p;
        rem_t       rem;
        den_t       den;
    } pl_t;

    localparam longint DEC_ONE           = 64'd1000000000000000000;
    localparam longint TWO_PI_DEC        = 64'd6283185307179586000;
    localparam longint HALF_PI_DEC       = 64'd1570796326794896500;
    localparam longint THREE_HALF_PI_DEC = 64'd4712388980384689500;
    localparam longint TWO_OVER_PI_DEC   = 64'd636619772367581343;
    localparam longint LN2_DEC           = 64'd693147180559945309;

    localparam longint LOW_DEC [0:18] = '{
        64'd55905663947151323, 64'd0, 64'd176308874389812, 64'd0,
        64'd1266274146116, 64'd0, 64'd11717181813, 64'd0, 64'd123006413, 64'd0,
        64'd1395273, 64'd0, 64'd16691, 64'd0, 64'd208, 64'd0, 64'd3, 64'd0, 64'd0
    };

    localparam longint HIGH_DEC [0:31] = '{
        64'd0, -64'sd960709721490083588, 64'd0, 64'd43936611519113928, 64'd0,
        64'd780149059052175, 64'd0, 64'd26219848932606, 64'd0, 64'd1092924974726,
        64'd0, 64'd51226183439, 64'd0, 64'd2588635127, 64'd0, 64'd137875455,
        64'd0, 64'd7634487, 64'd0, 64'd435569, 64'd0, 64'd25447, 64'd0, 64'd1516,
        64'd0, 64'd92, 64'd0, 64'd6, 64'd0, 64'd0, 64'd0, 64'd0
    };

    // round(num * 2^fb / den), restoring long division
    function automatic logic [63:0] udiv_frac(input logic [63:0] num,
                                              input logic [63:0] den, input int fb);
        logic [65:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[64:0], num[i]};
            q = {q[62:0], 1'b0};
            if (r >= {2'b00, den}) begin
                r    = r - {2'b00, den};
                q[0] = 1'b1;
            end
        end
        for (int i = 0; i < fb; i++) begin
            r = {r[64:0], 1'b0};
            q = {q[62:0], 1'b0};
            if (r >= {2'b00, den}) begin
                r    = r - {2'b00, den};
                q[0] = 1'b1;
            end
        end
        r = {r[64:0], 1'b0};
        if (r >= {2'b00, den}) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    function automatic q_t dec_to_q(input longint v, input int fb);
        logic [63:0] mag;
        q_t          q;
        mag = (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
        q   = q_t'(udiv_frac(mag, 64'(DEC_ONE), fb));
        return (v < 0) ? -q : q;
    endfunction

    function automatic q_t low_coef(input int i, input int n);
        q_t c;
        c = '0;
        if (i < n && i < LOW_MAX && i >= 0) begin
            c = dec_to_q(LOW_DEC[i], FRAC);
        end
        return c;
    endfunction

    function automatic q_t high_coef(input int i, input int n);
        q_t c;
        c = '0;
        if (i < n && i < HIGH_MAX && i >= 0) begin
            c = dec_to_q(HIGH_DEC[i], FRAC);
        end
        return c;
    endfunction

    function automatic q_t inv_odd(input int k);
        return q_t'(udiv_frac(64'd1, 64'(2 * k + 1), FRAC));
    endfunction

    function automatic logic [63:0] umag(input q_t v);
        logic [63:0] vu;
        vu = v;
        return vu[63] ? (~vu + 64'd1) : vu;
    endfunction

    // shift right, round to nearest, ties away from zero
    function automatic q_t rshift_round(input q_t v, input int s);
        logic [64:0] u;
        logic [63:0] r;
        u = {1'b0, umag(v)};
        u = (u + (65'd1 << (s - 1))) >> s;
        r = u[63:0];
        return v[63] ? q_t'(-r) : q_t'(r);
    endfunction

    localparam q_t ONE_Q = q_t'(64'd1 << FRAC);
    localparam q_t TP40  = dec_to_q(TWO_PI_DEC, 40);
    localparam q_t HP40  = dec_to_q(HALF_PI_DEC, 40);
    localparam q_t TP    = dec_to_q(TWO_PI_DEC, FRAC);
    localparam q_t HP    = dec_to_q(HALF_PI_DEC, FRAC);
    localparam q_t THP   = dec_to_q(THREE_HALF_PI_DEC, FRAC);
    localparam q_t TOP   = dec_to_q(TWO_OVER_PI_DEC, FRAC);
    localparam q_t LN2   = dec_to_q(LN2_DEC, FRAC);

    localparam logic [RED_W-1:0] RED_BIAS = RED_W'(HP40 + (TP40 <<< (KQ_W - 1)));
    localparam logic [RED_W-1:0] TP40_U   = RED_W'(TP40);

endpackage

/* sv/cl2_mul2.sv */
module cl2_mul2 (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  cl2_pkg::pl_t  in_pl,
    input  cl2_pkg::q_t   a0,
    input  cl2_pkg::q_t   b0,
    input  cl2_pkg::q_t   a1,
    input  cl2_pkg::q_t   b1,
    output logic          out_valid,
    output cl2_pkg::pl_t  out_pl,
    output cl2_pkg::q_t   p0,
    output cl2_pkg::q_t   p1
);
    import cl2_pkg::*;

    // two Q56 multipliers: partial products, sum, round/saturate
    logic [2:0]   vld_reg;
    pl_t          pl1_reg, pl2_reg, pl3_reg;
    q_t           a [2];
    q_t           b [2];
    logic [1:0]   neg_next, neg1_reg, neg2_reg;
    logic [63:0]  ll_next [2], m1_next [2], m2_next [2], hh_next [2];
    logic [63:0]  ll_reg [2], m1_reg [2], m2_reg [2], hh_reg [2];
    logic [127:0] sum_next [2], sum_reg [2];
    q_t           prod_next [2], prod_reg [2];

    assign a[0] = a0;
    assign b[0] = b0;
    assign a[1] = a1;
    assign b[1] = b1;

    always_comb begin
        logic [63:0] ua, ub, r;
        for (int l = 0; l < 2; l++) begin
            ua          = umag(a[l]);
            ub          = umag(b[l]);
            neg_next[l] = a[l][63] ^ b[l][63];
            ll_next[l]  = ua[31:0] * ub[31:0];
            m1_next[l]  = ua[63:32] * ub[31:0];
            m2_next[l]  = ua[31:0] * ub[63:32];
            hh_next[l]  = ua[63:32] * ub[63:32];
            sum_next[l] = {hh_reg[l], 64'd0} + {32'd0, m1_reg[l], 32'd0}
                        + {32'd0, m2_reg[l], 32'd0} + {64'd0, ll_reg[l]}
                        + (128'd1 << (FRAC - 1));
            r = (|sum_reg[l][127:119]) ? 64'h7FFF_FFFF_FFFF_FFFF : sum_reg[l][119:56];
            prod_next[l] = neg2_reg[l] ? q_t'(-r) : q_t'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl1_reg  <= in_pl;
            pl2_reg  <= pl1_reg;
            pl3_reg  <= pl2_reg;
            neg1_reg <= neg_next;
            neg2_reg <= neg1_reg;
            for (int l = 0; l < 2; l++) begin
                ll_reg[l]   <= ll_next[l];
                m1_reg[l]   <= m1_next[l];
                m2_reg[l]   <= m2_next[l];
                hh_reg[l]   <= hh_next[l];
                sum_reg[l]  <= sum_next[l];
                prod_reg[l] <= prod_next[l];
            end
        end
    end

    assign out_valid = vld_reg[2];
    assign out_pl    = pl3_reg;
    assign p0        = prod_reg[0];
    assign p1        = prod_reg[1];

endmodule

/* sv/cl2_reduce.sv */
module cl2_reduce (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] in_x,
    output logic               out_valid,
    output cl2_pkg::q_t        out_w
);
    import cl2_pkg::*;

    // floor((x + pi/2) / 2pi) by restoring division, then w = x - k*2pi
    logic [KQ_W:0]      vld_reg;
    logic [RED_W-1:0]   rem_reg [0:KQ_W];
    logic [KQ_W-1:0]    q_reg [0:KQ_W];
    logic signed [31:0] x_reg [0:KQ_W];
    logic [2:0]         tail_vld_reg;
    q_t                 prod_reg, w_reg, wf_reg;
    logic signed [31:0] xm_reg;
    logic signed [KQ_W:0] k;
    q_t                 prod_next, w_next, wf_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            tail_vld_reg <= '0;
        end else if (en) begin
            vld_reg      <= {vld_reg[KQ_W-1:0], in_valid};
            tail_vld_reg <= {tail_vld_reg[1:0], vld_reg[KQ_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {{2{in_x[31]}}, in_x, 20'd0} + RED_BIAS;
            q_reg[0]   <= '0;
            x_reg[0]   <= in_x;
        end
    end

    for (genvar j = 1; j <= KQ_W; j++) begin : g_div
        localparam logic [RED_W-1:0] DV = TP40_U << (KQ_W - j);
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j] <= x_reg[j-1];
                if (rem_reg[j-1] >= DV) begin
                    rem_reg[j] <= rem_reg[j-1] - DV;
                    q_reg[j]   <= q_reg[j-1] | (KQ_W'(1) << (KQ_W - j));
                end else begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
            end
        end
    end

    always_comb begin
        k         = $signed({1'b0, q_reg[KQ_W]}) - $signed((KQ_W+1)'(1) << (KQ_W - 1));
        prod_next = q_t'(k) * TP;
        w_next    = (q_t'(xm_reg) <<< 36) - prod_reg;
        if (w_reg < -HP) begin
            wf_next = w_reg + TP;
        end else if (w_reg >= THP) begin
            wf_next = w_reg - TP;
        end else begin
            wf_next = w_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            xm_reg   <= x_reg[KQ_W];
            w_reg    <= w_next;
            wf_reg   <= wf_next;
        end
    end

    assign out_valid = tail_vld_reg[2];
    assign out_w     = wf_reg;

endmodule

/* sv/cl2_clen_step.sv */
module cl2_clen_step #(
    parameter cl2_pkg::q_t CL = '0,
    parameter cl2_pkg::q_t CH = '0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  cl2_pkg::pl_t  in_pl,
    output logic          out_valid,
    output cl2_pkg::pl_t  out_pl
);
    import cl2_pkg::*;

    // one Clenshaw iteration for both series
    logic mv;
    pl_t  mpl, pl_next, pl_reg;
    q_t   pl0, ph0;
    logic vld_reg;

    cl2_mul2 u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid),
        .in_pl    (in_pl),
        .a0       (in_pl.t2l),
        .b0       (in_pl.bl0),
        .a1       (in_pl.t2h),
        .b1       (in_pl.bh0),
        .out_valid(mv),
        .out_pl   (mpl),
        .p0       (pl0),
        .p1       (ph0)
    );

    always_comb begin
        pl_next     = mpl;
        pl_next.bl0 = pl0 - mpl.bl1 + CL;
        pl_next.bl1 = mpl.bl0;
        pl_next.bl2 = mpl.bl1;
        pl_next.bh0 = ph0 - mpl.bh1 + CH;
        pl_next.bh1 = mpl.bh0;
        pl_next.bh2 = mpl.bh1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= mv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg <= pl_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_pl    = pl_reg;

endmodule

/* sv/cl2_log.sv */
module cl2_log (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  cl2_pkg::pl_t  in_pl,
    output logic          out_valid,
    output cl2_pkg::pl_t  out_pl
);
    import cl2_pkg::*;

    localparam int DIV_STEPS = FRAC;
    localparam int SER_STEPS = LOG_TERMS - 1;
    localparam q_t INV_LAST  = inv_odd(LOG_TERMS - 1);

    // ln|w| = e*ln2 + 2*s*sum(s^2j/(2j+1)), s = (f-1)/(f+1); also cube of w
    pl_t        pre_next, pre_reg, nrm_next, nrm_reg;
    logic [1:0] pre_vld_reg;
    logic [63:0] mu;
    logic [56:0] m;
    logic [5:0]  lead;
    logic [56:0] f;

    always_comb begin
        mu   = umag(in_pl.w);
        m    = mu[56:0];
        lead = '0;
        for (int i = 0; i < 57; i++) begin
            if (m[i]) begin
                lead = 6'(i);
            end
        end
        pre_next     = in_pl;
        pre_next.p   = lead;
        pre_next.rem = rem_t'(m);
        pre_next.dl  = in_pl.bl0 - in_pl.bl2;

        f            = pre_reg.rem[56:0] << (6'd56 - pre_reg.p);
        nrm_next     = pre_reg;
        nrm_next.rem = rem_t'(f[55:0]);
        nrm_next.den = {1'b0, f} + (den_t'(1) << FRAC);
        nrm_next.s   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg <= '0;
        end else if (en) begin
            pre_vld_reg <= {pre_vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg <= pre_next;
            nrm_reg <= nrm_next;
        end
    end

    // quotient s, one bit per stage, then a rounding stage
    pl_t  dv_pl_reg [0:DIV_STEPS];
    logic [DIV_STEPS:0] dv_vld_reg;
    pl_t  rnd_next, rnd_reg;
    logic rnd_vld_reg;

    always_comb begin
        dv_pl_reg[0]  = nrm_reg;
        dv_vld_reg[0] = pre_vld_reg[1];
    end

    for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
        pl_t  st_next;
        rem_t r2;
        always_comb begin
            st_next   = dv_pl_reg[i-1];
            r2        = {dv_pl_reg[i-1].rem[57:0], 1'b0};
            st_next.s = dv_pl_reg[i-1].s <<< 1;
            if (r2 >= {1'b0, dv_pl_reg[i-1].den}) begin
                st_next.rem  = r2 - {1'b0, dv_pl_reg[i-1].den};
                st_next.s[0] = 1'b1;
            end else begin
                st_next.rem = r2;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_pl_reg[i] <= st_next;
            end
        end
    end

    always_comb begin
        rnd_next = dv_pl_reg[DIV_STEPS];
        if ({dv_pl_reg[DIV_STEPS].rem[57:0], 1'b0} >= {1'b0, dv_pl_reg[DIV_STEPS].den}) begin
            rnd_next.s = dv_pl_reg[DIV_STEPS].s + q_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_vld_reg <= 1'b0;
        end else if (en) begin
            rnd_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg <= rnd_next;
        end
    end

    // s^2 and w^3
    logic sq_mv, sq_vld_reg;
    pl_t  sq_mpl, sq_next, sq_reg;
    q_t   sq_p0, sq_p1;

    cl2_mul2 u_sq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rnd_vld_reg),
        .in_pl    (rnd_reg),
        .a0       (rnd_reg.s),
        .b0       (rnd_reg.s),
        .a1       (rnd_reg.ww),
        .b1       (rnd_reg.w),
        .out_valid(sq_mv),
        .out_pl   (sq_mpl),
        .p0       (sq_p0),
        .p1       (sq_p1)
    );

    always_comb begin
        sq_next      = sq_mpl;
        sq_next.s2   = sq_p0;
        sq_next.cube = sq_p1;
        sq_next.sum  = INV_LAST;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg <= sq_mv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    // odd-power series, Horner form
    pl_t  sr_pl [0:SER_STEPS];
    logic [SER_STEPS:0] sr_vld;

    assign sr_pl[0]  = sq_reg;
    assign sr_vld[0] = sq_vld_reg;

    for (genvar j = 1; j <= SER_STEPS; j++) begin : g_ser
        localparam q_t INV_K = inv_odd(SER_STEPS - j);
        logic mv, vld_reg;
        pl_t  mpl, st_next, st_reg;
        q_t   mp0, mp1;

        cl2_mul2 u_ser (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sr_vld[j-1]),
            .in_pl    (sr_pl[j-1]),
            .a0       (sr_pl[j-1].s2),
            .b0       (sr_pl[j-1].sum),
            .a1       ('0),
            .b1       ('0),
            .out_valid(mv),
            .out_pl   (mpl),
            .p0       (mp0),
            .p1       (mp1)
        );

        always_comb begin
            st_next     = mpl;
            st_next.sum = INV_K + mp0;
            st_next.lg  = mp1;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= mv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg <= st_next;
            end
        end

        assign sr_pl[j]  = st_reg;
        assign sr_vld[j] = vld_reg;
    end

    // ln = (p - 56)*ln2 + 2*s*sum
    logic             ln_mv, ln_vld_reg;
    pl_t              ln_mpl, ln_next, ln_reg;
    q_t               ln_p0, ln_p1;
    logic signed [7:0] pe;

    cl2_mul2 u_ln (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (sr_vld[SER_STEPS]),
        .in_pl    (sr_pl[SER_STEPS]),
        .a0       (sr_pl[SER_STEPS].s),
        .b0       (sr_pl[SER_STEPS].sum),
        .a1       ('0),
        .b1       ('0),
        .out_valid(ln_mv),
        .out_pl   (ln_mpl),
        .p0       (ln_p0),
        .p1       (ln_p1)
    );

    always_comb begin
        pe         = $signed({2'b00, ln_mpl.p}) - 8'sd56;
        ln_next    = ln_mpl;
        ln_next.lg = q_t'(pe) * LN2 + (ln_p0 <<< 1) + (ln_p1 & q_t'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ln_vld_reg <= 1'b0;
        end else if (en) begin
            ln_vld_reg <= ln_mv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ln_reg <= ln_next;
        end
    end

    assign out_valid = ln_vld_reg;
    assign out_pl    = ln_reg;

endmodule

/* sv/clausen_cl2_evaluator_unit.sv */
// Channel   Dir  tdata bits            Transaction
// s_        in   [31:0] arg_x (Q11.20)  one argument
// m_        out  [31:0] cl2_value (Q3.28) one Cl2 value
//
// One argument per cycle; the path runs through range reduction, scaling,
// Clenshaw, logarithm, final combine and rounding, and the output register.
// Throughput is set by the fully pipelined Q56 multiplier pairs and divider.
// aresetn clears all valid bits; payload registers are not reset.
// The pipeline freezes only while the output skid register is occupied.
module clausen_cl2_evaluator_unit #(
    parameter int LOW_BRANCH_TERMS  = cl2_pkg::LOW_BRANCH_TERMS_DEF,
    parameter int HIGH_BRANCH_TERMS = cl2_pkg::HIGH_BRANCH_TERMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] arg_x
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] cl2_value
);
    import cl2_pkg::*;

    logic en;
    logic skid_valid_reg, out_valid_reg;
    logic [31:0] skid_data_reg, out_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // range reduction
    logic red_v;
    q_t   red_w;
    pl_t  red_pl;

    cl2_reduce u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid && s_tready),
        .in_x     ($signed(s_tdata)),
        .out_valid(red_v),
        .out_w    (red_w)
    );

    always_comb begin
        red_pl   = '0;
        red_pl.w = red_w;
    end

    // t = 2w/pi, w^2
    logic sc_mv, sc_vld_reg;
    pl_t  sc_mpl, sc_next, sc_reg;
    q_t   sc_p0, sc_p1;

    cl2_mul2 u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (red_v),
        .in_pl    (red_pl),
        .a0       (red_w),
        .b0       (TOP),
        .a1       (red_w),
        .b1       (red_w),
        .out_valid(sc_mv),
        .out_pl   (sc_mpl),
        .p0       (sc_p0),
        .p1       (sc_p1)
    );

    always_comb begin
        sc_next     = sc_mpl;
        sc_next.t2l = sc_p0 <<< 1;
        sc_next.t2h = (sc_p0 - (ONE_Q <<< 1)) <<< 1;
        sc_next.ww  = sc_p1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_vld_reg <= 1'b0;
        end else if (en) begin
            sc_vld_reg <= sc_mv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg <= sc_next;
        end
    end

    // Clenshaw, highest index first; unused top terms run with zero coefficients
    pl_t  cs_pl [0:CLEN_ITERS];
    logic [CLEN_ITERS:0] cs_vld;

    assign cs_pl[0]  = sc_reg;
    assign cs_vld[0] = sc_vld_reg;

    for (genvar j = 0; j < CLEN_ITERS; j++) begin : g_clen
        localparam q_t CLV = low_coef(CLEN_ITERS - 1 - j, LOW_BRANCH_TERMS);
        localparam q_t CHV = high_coef(CLEN_ITERS - 1 - j, HIGH_BRANCH_TERMS);
        cl2_clen_step #(
            .CL(CLV),
            .CH(CHV)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cs_vld[j]),
            .in_pl    (cs_pl[j]),
            .out_valid(cs_vld[j+1]),
            .out_pl   (cs_pl[j+1])
        );
    end

    // logarithm and cube
    logic lg_v;
    pl_t  lg_pl;

    cl2_log u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (cs_vld[CLEN_ITERS]),
        .in_pl    (cs_pl[CLEN_ITERS]),
        .out_valid(lg_v),
        .out_pl   (lg_pl)
    );

    // w*ln|w| and w^3*S1, branch select
    logic fm_v, fin_vld_reg, rnd_vld_reg;
    pl_t  fm_pl;
    q_t   fm_p0, fm_p1, val_next, val_reg, rs;
    logic [31:0] res_next, res_reg;

    cl2_mul2 u_final (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (lg_v),
        .in_pl    (lg_pl),
        .a0       (lg_pl.w),
        .b0       (lg_pl.lg),
        .a1       (lg_pl.cube),
        .b1       (lg_pl.dl),
        .out_valid(fm_v),
        .out_pl   (fm_pl),
        .p0       (fm_p0),
        .p1       (fm_p1)
    );

    always_comb begin
        if (fm_pl.w == '0) begin
            val_next = '0;
        end else if (fm_pl.w < HP) begin
            val_next = fm_pl.w - fm_p0 + rshift_round(fm_p1, 2);
        end else begin
            val_next = rshift_round(fm_pl.bh0 - fm_pl.bh2, 1);
        end
        rs = rshift_round(val_reg, 28);
        if (rs > q_t'(64'sd2147483647)) begin
            res_next = 32'h7FFF_FFFF;
        end else if (rs < -q_t'(64'sd2147483648)) begin
            res_next = 32'h8000_0000;
        end else begin
            res_next = rs[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
            rnd_vld_reg <= 1'b0;
        end else if (en) begin
            fin_vld_reg <= fm_v;
            rnd_vld_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= val_next;
            res_reg <= res_next;
        end
    end

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= rnd_vld_reg;
            end else if (rnd_vld_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res_reg;
            end else begin
                skid_data_reg <= res_reg;
            end
        end else if (m_tready) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready && rnd_vld_reg))
        else $error("skid filled without a blocked output");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !skid_valid_reg)
        else $error("output not empty after reset");

endmodule
